>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define TCW_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed: %m");

// Check on every clock edge, reset included.
`define TCW_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("assertion failed: %m");

`endif

>>> sv/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int COPY_LEN   = (ROWS - 1) * COLUMNS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int POS_W  = 11;
    localparam int CHAR_W = 8;
    localparam int CELL_W = 16;

    localparam logic KIND_PUT  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] ATTR_RESET   = 8'h0F;
    localparam logic [CELL_W-1:0] CELL_RESET   = {ATTR_RESET, CH_SPACE};

    typedef struct packed {
        logic              kind;
        logic [CHAR_W-1:0] char_code;
        logic [10:0]       cell_address;
    } t_in_item;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_line;
        logic [POS_W-1:0]  cursor_position;
        logic [CELL_W-1:0] cell_word;
    } t_out_item;

    // Cursor update for one put byte.
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [CHAR_W-1:0] wr_char;
        logic              scroll;
    } t_cur_upd;

endpackage

`default_nettype wire

>>> sv/tcw_ram.sv
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> sv/tcw_cursor.sv
`default_nettype none

module tcw_cursor
    import tcw_pkg::*;
(
    input  wire logic [COL_W-1:0]  i_col,
    input  wire logic [ROW_W-1:0]  i_row,
    input  wire logic [CHAR_W-1:0] i_char,
    output t_cur_upd               o_upd
);

    logic [COL_W:0]    ncol;
    logic [ROW_W:0]    nrow;
    logic [COL_W-1:0]  wcol;
    logic [CHAR_W-1:0] wchar;
    logic              wr;
    logic              scroll;

    always_comb begin
        ncol  = {1'b0, i_col};
        nrow  = {1'b0, i_row};
        wcol  = i_col;
        wchar = i_char;
        wr    = 1'b0;
        unique case (i_char)
            CH_NEWLINE: begin
                ncol = '0;
                nrow = nrow + 1'b1;
            end
            CH_RETURN: begin
                ncol = '0;
            end
            CH_TAB: begin
                ncol = ({1'b0, i_col} + (COL_W+1)'(8)) & ~(COL_W+1)'(7);
            end
            CH_BACKSPACE: begin
                if (i_col != '0) begin
                    ncol  = {1'b0, i_col} - 1'b1;
                    wcol  = i_col - 1'b1;
                    wchar = CH_SPACE;
                    wr    = 1'b1;
                end
            end
            default: begin
                wr   = 1'b1;
                ncol = {1'b0, i_col} + 1'b1;
            end
        endcase

        // wrap at the line end
        if (ncol >= (COL_W+1)'(COLUMNS)) begin
            ncol = '0;
            nrow = nrow + 1'b1;
        end
        scroll = (nrow >= (ROW_W+1)'(ROWS));

        o_upd.col     = ncol[COL_W-1:0];
        o_upd.row     = scroll ? ROW_W'(ROWS - 1) : nrow[ROW_W-1:0];
        o_upd.wr_en   = wr;
        o_upd.wr_addr = ADDR_W'(ADDR_W'(i_row) * ADDR_W'(COLUMNS) + ADDR_W'(wcol));
        o_upd.wr_char = wchar;
        o_upd.scroll  = scroll;
    end

endmodule

`default_nettype wire

>>> sv/text_console_writer_top.sv
// Channel  Handshake                 Word          Meaning
// in       i_in_valid / o_in_ready   i_in_word     put a byte or read one cell
// out      o_out_valid / i_out_ready o_out_word    cursor after the item, read cell
// cfg      i_cfg_valid / o_cfg_ready i_cfg_data    text attribute byte
//
// A put steps through accept, execute and finish; a read adds a data step after
// execute, skipped for an address past the screen. A put that passes the last row
// adds a scroll that copies each row up one row through the one write and one read
// port, then blanks the last row. After reset a clearing pass writes blank cells to
// all cells; no word is taken meanwhile, configuration writes are taken always.
// A result waits in the output register; the last step stalls only while it is full.
`default_nettype none

module text_console_writer_top
    import tcw_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_item          i_in_word,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out_word,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CHAR_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RDATA,
        ST_SCROLL,
        ST_FILL,
        ST_FINISH
    } t_state;

    // Sequencer state
    t_state            r_state,     n_state;
    logic [ADDR_W-1:0] r_cnt,       n_cnt;
    logic [COL_W-1:0]  r_col,       n_col;
    logic [ROW_W-1:0]  r_row,       n_row;
    logic [CHAR_W-1:0] r_attr,      n_attr;
    logic              r_out_valid, n_out_valid;

    // Payload
    t_in_item          r_item,      n_item;
    logic [CELL_W-1:0] r_word,      n_word;
    t_out_item         r_out,       n_out;

    // Screen store ports
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [CELL_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [CELL_W-1:0] ram_rd_data;

    t_cur_upd          upd;
    logic              out_free;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Decode the latched byte against the current cursor.
    tcw_cursor u_cursor (
        .i_col  (r_col),
        .i_row  (r_row),
        .i_char (r_item.char_code),
        .o_upd  (upd)
    );

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_col       = r_col;
        n_row       = r_row;
        n_attr      = i_cfg_valid ? i_cfg_data : r_attr;
        n_out_valid = r_out_valid && !i_out_ready;
        n_item      = r_item;
        n_word      = r_word;
        n_out       = r_out;

        ram_wr_en   = 1'b0;
        ram_wr_addr = r_cnt;
        ram_wr_data = CELL_RESET;
        ram_rd_en   = 1'b0;
        ram_rd_addr = ADDR_W'(r_cnt + ADDR_W'(COLUMNS));

        unique case (r_state)
            ST_CLEAR: begin
                // sweep the store to blank cells, one per cycle
                ram_wr_en = 1'b1;
                if (r_cnt == ADDR_W'(CELL_COUNT - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_word;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_word = '0;
                if (r_item.kind == KIND_READ) begin
                    // out-of-range addresses give a zero cell, no access
                    if (r_item.cell_address < 11'(CELL_COUNT)) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = ADDR_W'(r_item.cell_address);
                        n_state     = ST_RDATA;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end else begin
                    ram_wr_en   = upd.wr_en;
                    ram_wr_addr = upd.wr_addr;
                    ram_wr_data = {r_attr, upd.wr_char};
                    n_col       = upd.col;
                    n_row       = upd.row;
                    if (upd.scroll) begin
                        n_cnt   = '0;
                        n_state = ST_SCROLL;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_RDATA: begin
                n_word  = ram_rd_data;
                n_state = ST_FINISH;
            end
            ST_SCROLL: begin
                // read cell cnt+COLUMNS, write the cell read last cycle one row up
                ram_rd_en   = (r_cnt != ADDR_W'(COPY_LEN));
                ram_wr_en   = (r_cnt != '0);
                ram_wr_addr = r_cnt - 1'b1;
                ram_wr_data = ram_rd_data;
                if (r_cnt == ADDR_W'(COPY_LEN)) begin
                    n_state = ST_FILL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_FILL: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = {r_attr, CH_SPACE};
                if (r_cnt == ADDR_W'(CELL_COUNT - 1)) begin
                    n_state = ST_FINISH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out.cursor_column   = r_col;
                    n_out.cursor_line     = r_row;
                    n_out.cursor_position =
                        POS_W'(ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col));
                    n_out.cell_word       = r_word;
                    n_state               = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_word <= n_word;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_attr      <= ATTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_col       <= n_col;
            r_row       <= n_row;
            r_attr      <= n_attr;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

>>> sv/tcw_checker.sv
`default_nettype none
`include "assert_macros.svh"

module tcw_checker
    import tcw_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_word
);

    logic cursor_in_range;
    logic cursor_pos_ok;

    assign cursor_in_range = int'(o_out_word.cursor_column) < COLUMNS &&
                             int'(o_out_word.cursor_line) < ROWS;
    assign cursor_pos_ok   = int'(o_out_word.cursor_position) ==
        int'(o_out_word.cursor_line) * COLUMNS + int'(o_out_word.cursor_column);

    // after a reset edge: nothing offered, clearing pass blocks new words
    `TCW_ASSERT_ALWAYS(a_reset_quiet, (!i_rst_n) |=> (!o_out_valid && !o_in_ready))

    // one word at a time: ready drops after an accept
    `TCW_ASSERT(a_one_at_a_time, (i_in_valid && o_in_ready) |=> !o_in_ready)

    // cursor stays on the screen
    `TCW_ASSERT(a_cursor_range, o_out_valid |-> cursor_in_range)

    // linear position matches line and column
    `TCW_ASSERT(a_cursor_pos, o_out_valid |-> cursor_pos_ok)

    // a stalled result holds
    `TCW_ASSERT(a_out_hold, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_word)))

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (.*);

`default_nettype wire
